[rtl/core/nsfc_pkg.sv]
// Shared types, character codes and helpers for the NMEA sentence framer and checker.
`timescale 1ns / 1ps

package nsfc_pkg;

   // Characters that steer framing and the checksum
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // Header bytes kept after the dollar
   localparam int unsigned HDR_DEPTH = 7;
   localparam int unsigned HDR_BITS  = HDR_DEPTH * 8;

   // Reset value of the line length register
   localparam logic [7:0] MAX_LINE_LEN_RESET = 8'd128;

   // Shortest line that is checked at all
   localparam logic [7:0] MIN_LINE_LEN = 8'd4;

   // Prefixes for the kind match
   localparam logic [15:0] TALKER_GP = "GP";
   localparam logic [15:0] TALKER_GN = "GN";
   localparam logic [15:0] TALKER_BD = "BD";
   localparam logic [15:0] TALKER_GA = "GA";
   localparam logic [23:0] TYPE_RMC  = "RMC";
   localparam logic [23:0] TYPE_GGA  = "GGA";
   localparam logic [HDR_BITS-1:0] PMTK011_STR = "PMTK011";
   localparam logic [HDR_BITS-1:0] PMTK001_STR = "PMTK001";

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_MALFORMED = 2'd2,
      STATUS_MISMATCH  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_OTHER   = 3'd0,
      KIND_RMC     = 3'd1,
      KIND_GGA     = 3'd2,
      KIND_PMTK011 = 3'd3,
      KIND_PMTK001 = 3'd4
   } kind_type;

   // One result as it leaves the framer
   typedef struct packed {
      status_type status;
      kind_type   kind;
      logic [7:0] length;
      logic [7:0] computed;
      logic [7:0] received;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   // Decode one ASCII hex digit, either case
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b0;
      h.value = 4'd0;
      if (c >= "0" && c <= "9") begin
         h.valid = 1'b1;
         h.value = 4'(c - 8'h30);
      end else if (c >= "a" && c <= "f") begin
         h.valid = 1'b1;
         h.value = 4'(c - 8'h57);
      end else if (c >= "A" && c <= "F") begin
         h.valid = 1'b1;
         h.value = 4'(c - 8'h37);
      end
      return h;
   endfunction

endpackage

[rtl/core/nmea_sentence_framer_checker.sv]
// Top level: request register, framer, result register and line length register.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_rx_byte
//   rsp       out        rsp_valid/rsp_ready    status, kind, length, checksums
//   csr       in         csr_wr_en              csr_wr_data (max_line_len)
//
// One request a cycle unless the result register stalls: a byte moves from the request
// register through the framer into the result register, so a line end shows its result
// once it has passed both registers. Reset is synchronous and clears all control state
// and sets max_line_len to 128. A stalled result register holds the request register,
// which keeps taking one more request before req_ready drops.
`timescale 1ns / 1ps

module nmea_sentence_framer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_sentence_kind,
   output logic [7:0] rsp_sentence_length,
   output logic [7:0] rsp_computed_checksum,
   output logic [7:0] rsp_received_checksum,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0] max_line_len_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   nsfc_pkg::result_type out_ff;
   nsfc_pkg::result_type result;
   logic       advance;
   logic       fire;

   // Move a byte on when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   nsfc_framer u_framer (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .max_line_len (max_line_len_ff),
      .fire         (fire),
      .result       (result)
   );

   // Hold or replace the request register
   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Load a result on a line end, drop it once taken
   always_comb begin
      if (advance) begin
         out_valid_in = fire;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         max_line_len_ff <= nsfc_pkg::MAX_LINE_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_line_len_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_ff.status;
   assign rsp_sentence_kind     = out_ff.kind;
   assign rsp_sentence_length   = out_ff.length;
   assign rsp_computed_checksum = out_ff.computed;
   assign rsp_received_checksum = out_ff.received;

endmodule

[rtl/core/nsfc_kind.sv]
// Sentence kind match on the header bytes that follow the dollar.
`timescale 1ns / 1ps

module nsfc_kind (
   input  logic [nsfc_pkg::HDR_BITS-1:0] header,
   output nsfc_pkg::kind_type            kind
);

   logic talker;
   logic is_rmc;
   logic is_gga;

   // Talker sits in the first two bytes, sentence type in the next three
   assign talker = (header[55:40] == nsfc_pkg::TALKER_GP) ||
                   (header[55:40] == nsfc_pkg::TALKER_GN) ||
                   (header[55:40] == nsfc_pkg::TALKER_BD) ||
                   (header[55:40] == nsfc_pkg::TALKER_GA);
   assign is_rmc = talker && (header[39:16] == nsfc_pkg::TYPE_RMC);
   assign is_gga = talker && (header[39:16] == nsfc_pkg::TYPE_GGA);

   // First match wins
   always_comb begin
      if (is_rmc) begin
         kind = nsfc_pkg::KIND_RMC;
      end else if (is_gga) begin
         kind = nsfc_pkg::KIND_GGA;
      end else if (header == nsfc_pkg::PMTK011_STR) begin
         kind = nsfc_pkg::KIND_PMTK011;
      end else if (header == nsfc_pkg::PMTK001_STR) begin
         kind = nsfc_pkg::KIND_PMTK001;
      end else begin
         kind = nsfc_pkg::KIND_OTHER;
      end
   end

endmodule

[rtl/core/nsfc_framer.sv]
// Line framing state, running checksum, star digit parse and result build.
`timescale 1ns / 1ps

module nsfc_framer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             max_line_len,
   output logic                   fire,
   output nsfc_pkg::result_type   result
);

   logic [7:0] count_ff, count_in;
   logic [7:0] xor_ff, xor_in;
   logic       star_ff, star_in;
   logic [1:0] digits_ff, digits_in;
   logic [7:0] value_ff, value_in;
   logic       bad_ff, bad_in;
   logic [7:0] header_ff [nsfc_pkg::HDR_DEPTH];
   logic [7:0] header_in [nsfc_pkg::HDR_DEPTH];

   logic [nsfc_pkg::HDR_BITS-1:0] header_word;
   nsfc_pkg::kind_type            kind;
   nsfc_pkg::hex_type             hex;
   logic [7:0]                    count_next;
   logic [2:0]                    hdr_idx;
   logic                          hdr_wr;
   logic                          drop;

   assign hex        = nsfc_pkg::hex_decode(rx_byte);
   assign hdr_idx    = count_ff[2:0] - 3'd1;
   assign hdr_wr     = (count_ff <= 8'(nsfc_pkg::HDR_DEPTH));
   // A new dollar starts the line at one byte
   assign count_next = (count_ff == 8'd0) ? 8'd1 : count_ff + 8'd1;
   // Drop once the count reaches max_line_len - 3 (also for tiny limits)
   assign drop       = ({1'b0, count_next} + 9'd3) >= {1'b0, max_line_len};

   // Pack the header, first byte in the top bits
   always_comb begin
      for (int i = 0; i < nsfc_pkg::HDR_DEPTH; i++) begin
         header_word[nsfc_pkg::HDR_BITS-1-8*i -: 8] = header_ff[i];
      end
   end

   nsfc_kind u_kind (
      .header (header_word),
      .kind   (kind)
   );

   // Advance the line state by one byte
   always_comb begin
      count_in  = count_ff;
      xor_in    = xor_ff;
      star_in   = star_ff;
      digits_in = digits_ff;
      value_in  = value_ff;
      bad_in    = bad_ff;
      header_in = header_ff;
      fire      = 1'b0;
      if (step) begin
         if (count_ff == 8'd0) begin
            // Hunt for the dollar; everything else is skipped
            if (rx_byte == nsfc_pkg::CHAR_DOLLAR) begin
               xor_in    = 8'd0;
               star_in   = 1'b0;
               digits_in = 2'd0;
               value_in  = 8'd0;
               bad_in    = 1'b0;
               for (int i = 0; i < nsfc_pkg::HDR_DEPTH; i++) begin
                  header_in[i] = 8'd0;
               end
               count_in = drop ? 8'd0 : count_next;
            end
         end else if (rx_byte == nsfc_pkg::CHAR_LF || rx_byte == nsfc_pkg::CHAR_CR) begin
            // Close the line and report
            fire     = 1'b1;
            count_in = 8'd0;
         end else begin
            for (int i = 0; i < nsfc_pkg::HDR_DEPTH; i++) begin
               if (hdr_wr && hdr_idx == 3'(i)) begin
                  header_in[i] = rx_byte;
               end
            end
            if (!star_ff) begin
               if (rx_byte == nsfc_pkg::CHAR_STAR) begin
                  star_in = 1'b1;
               end else begin
                  xor_in = xor_ff ^ rx_byte;
               end
            end else if (!hex.valid || digits_ff >= 2'd2) begin
               bad_in = 1'b1;
            end else begin
               value_in  = {value_ff[3:0], hex.value};
               digits_in = digits_ff + 2'd1;
            end
            count_in = drop ? 8'd0 : count_next;
         end
      end
   end

   // Build the result from the state held before the line end
   always_comb begin
      if (count_ff < nsfc_pkg::MIN_LINE_LEN) begin
         result.status = nsfc_pkg::STATUS_SHORT;
      end else if (!star_ff || bad_ff) begin
         result.status = nsfc_pkg::STATUS_MALFORMED;
      end else if (value_ff != xor_ff) begin
         result.status = nsfc_pkg::STATUS_MISMATCH;
      end else begin
         result.status = nsfc_pkg::STATUS_OK;
      end
      result.kind     = kind;
      result.length   = count_ff;
      result.computed = xor_ff;
      result.received = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 8'd0;
         xor_ff    <= 8'd0;
         star_ff   <= 1'b0;
         digits_ff <= 2'd0;
         value_ff  <= 8'd0;
         bad_ff    <= 1'b0;
         for (int i = 0; i < nsfc_pkg::HDR_DEPTH; i++) begin
            header_ff[i] <= 8'd0;
         end
      end else begin
         count_ff  <= count_in;
         xor_ff    <= xor_in;
         star_ff   <= star_in;
         digits_ff <= digits_in;
         value_ff  <= value_in;
         bad_ff    <= bad_in;
         header_ff <= header_in;
      end
   end

endmodule

[rtl/core/nsfc_checker.sv]
// Port-level checks on the framer results, bound to the top level.
`timescale 1ns / 1ps

module nsfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_sentence_kind,
   input logic [7:0] rsp_sentence_length,
   input logic [7:0] rsp_computed_checksum,
   input logic [7:0] rsp_received_checksum
);

   // No result straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown in the cycle after reset");

   // A stalled result holds its status, length and computed checksum
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_sentence_length) && $stable(rsp_computed_checksum))
      else $error("stalled result changed");

   // An ok status means the checksums agree
   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == nsfc_pkg::STATUS_OK |->
      rsp_computed_checksum == rsp_received_checksum)
      else $error("ok status with differing checksums");

   // Too short exactly when under four bytes
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == nsfc_pkg::STATUS_SHORT) ==
      (rsp_sentence_length < nsfc_pkg::MIN_LINE_LEN)))
      else $error("too short status disagrees with length");

   // A known kind needs a header that long
   a_kind_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sentence_kind != nsfc_pkg::KIND_OTHER |->
      rsp_sentence_length >= 8'd6)
      else $error("kind reported for a line too short to hold its prefix");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_status            (rsp_status),
   .rsp_sentence_kind     (rsp_sentence_kind),
   .rsp_sentence_length   (rsp_sentence_length),
   .rsp_computed_checksum (rsp_computed_checksum),
   .rsp_received_checksum (rsp_received_checksum)
);
